[rtl/csfc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfc_pkg
// Shared types, codes and widths of the shift-cipher frequency cracker.
// ----------------------------------------------------------------------------
package csfc_pkg;

    // request codes
    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_BYTE = 2'd1;
    localparam logic [1:0] CMD_EVAL = 2'd2;

    localparam int NUM_LETTERS  = 26;
    localparam int LETTER_W     = 5;
    localparam int WEIGHT_IN_W  = 16;
    localparam int SCORE_W      = 45;

    localparam int DEF_COUNT_WIDTH  = 24;
    localparam int DEF_WEIGHT_WIDTH = 16;

    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(NUM_LETTERS - 1);
    localparam logic [LETTER_W-1:0] FIRST_SHIFT = LETTER_W'(1);
    localparam logic [LETTER_W-1:0] LAST_SHIFT  = LETTER_W'(NUM_LETTERS);

    localparam logic [7:0] UPPER_A = 8'd65;
    localparam logic [7:0] UPPER_Z = 8'd90;
    localparam logic [7:0] LOWER_A = 8'd97;
    localparam logic [7:0] LOWER_Z = 8'd122;

    localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

    // read addresses driven by the scoring sequencer
    typedef struct packed {
        logic                active;
        logic [LETTER_W-1:0] cnt_addr;
        logic [LETTER_W-1:0] wt_addr;
    } t_scan_rd;

endpackage

[rtl/csfc_hist.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfc_hist
// Letter histogram memory with a read-modify-write byte pipeline.
// ----------------------------------------------------------------------------
module csfc_hist import csfc_pkg::*; #(
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_byte_vld,
    input  logic [7:0]             i_char_code,
    input  t_scan_rd               i_scan,
    input  logic                   i_clear,
    output logic [COUNT_WIDTH-1:0] o_cnt_q
);

    logic [COUNT_WIDTH-1:0] mem [0:NUM_LETTERS-1];
    logic [NUM_LETTERS-1:0] r_vld;

    logic [COUNT_WIDTH-1:0] r_q;
    logic                   r_qv;

    logic                   r_p1_vld;
    logic [LETTER_W-1:0]    r_p1_idx;

    logic                   r_wr_vld;
    logic [LETTER_W-1:0]    r_wr_idx;
    logic [COUNT_WIDTH-1:0] r_wr_data;

    logic [7:0]             up_diff;
    logic [7:0]             lo_diff;
    logic                   is_upper;
    logic                   is_lower;
    logic [LETTER_W-1:0]    byte_idx;
    logic [LETTER_W-1:0]    rd_addr;
    logic [COUNT_WIDTH-1:0] cur_cnt;
    logic [COUNT_WIDTH-1:0] n_cnt;

    assign up_diff  = i_char_code - UPPER_A;
    assign lo_diff  = i_char_code - LOWER_A;
    assign is_upper = (i_char_code >= UPPER_A) && (i_char_code <= UPPER_Z);
    assign is_lower = (i_char_code >= LOWER_A) && (i_char_code <= LOWER_Z);
    assign byte_idx = is_upper ? up_diff[LETTER_W-1:0] : lo_diff[LETTER_W-1:0];
    assign rd_addr  = i_scan.active ? i_scan.cnt_addr : byte_idx;

    assign o_cnt_q = r_qv ? r_q : '0;

    // take the value held in the write stage when the same letter repeats
    assign cur_cnt = (r_wr_vld && (r_wr_idx == r_p1_idx)) ? r_wr_data : o_cnt_q;
    assign n_cnt   = (&cur_cnt) ? cur_cnt : cur_cnt + 1'b1;

    always_ff @(posedge i_clk) begin
        r_q  <= mem[rd_addr];
        r_qv <= r_vld[rd_addr];
        if (r_p1_vld) begin
            mem[r_p1_idx] <= n_cnt;
        end
        r_p1_idx  <= byte_idx;
        r_wr_idx  <= r_p1_idx;
        r_wr_data <= n_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_p1_vld <= 1'b0;
            r_wr_vld <= 1'b0;
        end else begin
            r_p1_vld <= i_byte_vld && (is_upper || is_lower);
            r_wr_vld <= r_p1_vld;
            if (i_clear) begin
                r_vld <= '0;
            end else if (r_p1_vld) begin
                r_vld[r_p1_idx] <= 1'b1;
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_write_during_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_scan.active |-> !r_p1_vld)
        else $error("byte write overlaps scan");
    a_clear_when_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_clear |-> (!r_p1_vld && !i_byte_vld))
        else $error("histogram cleared with a byte in flight");
`endif

endmodule

[rtl/csfc_wtab.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfc_wtab
// Reference weight memory, loaded per letter and read by the scan.
// ----------------------------------------------------------------------------
module csfc_wtab import csfc_pkg::*; #(
    parameter int WEIGHT_WIDTH = DEF_WEIGHT_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_load,
    input  logic [LETTER_W-1:0]     i_letter_index,
    input  logic [WEIGHT_IN_W-1:0]  i_weight,
    input  t_scan_rd                i_scan,
    output logic [WEIGHT_WIDTH-1:0] o_wt_q
);

    logic [WEIGHT_WIDTH-1:0] mem [0:NUM_LETTERS-1];
    logic [NUM_LETTERS-1:0]  r_vld;
    logic [WEIGHT_WIDTH-1:0] r_q;
    logic                    r_qv;
    logic [WEIGHT_WIDTH-1:0] w_sat;
    logic                    wr_en;

    generate
        if (WEIGHT_WIDTH >= WEIGHT_IN_W) begin : g_wide
            assign w_sat = WEIGHT_WIDTH'(i_weight);
        end else begin : g_narrow
            // clamp to the widest storable weight
            assign w_sat = (|i_weight[WEIGHT_IN_W-1:WEIGHT_WIDTH]) ? '1
                                                                   : i_weight[WEIGHT_WIDTH-1:0];
        end
    endgenerate

    assign wr_en  = i_load && (i_letter_index <= LAST_LETTER);
    assign o_wt_q = r_qv ? r_q : '0;

    always_ff @(posedge i_clk) begin
        r_q  <= mem[i_scan.wt_addr];
        r_qv <= r_vld[i_scan.wt_addr];
        if (wr_en) begin
            mem[i_letter_index] <= w_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (wr_en) begin
            r_vld[i_letter_index] <= 1'b1;
        end
    end

endmodule

[rtl/csfc_score.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfc_score
// Scan sequencer, multiplier and saturating accumulator that pick the best
// shift.
// ----------------------------------------------------------------------------
module csfc_score import csfc_pkg::*; #(
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
    parameter int WEIGHT_WIDTH = DEF_WEIGHT_WIDTH
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [COUNT_WIDTH-1:0]  i_cnt_q,
    input  logic [WEIGHT_WIDTH-1:0] i_wt_q,
    output t_scan_rd                o_scan,
    output logic                    o_done,
    output logic [LETTER_W-1:0]     o_best_shift,
    output logic [SCORE_W-1:0]      o_best_score
);

    localparam int PROD_W = COUNT_WIDTH + WEIGHT_WIDTH;
    localparam int SUM_W  = ((PROD_W > SCORE_W) ? PROD_W : SCORE_W) + 1;

    // issue stage
    logic                r_run;
    logic [LETTER_W-1:0] r_c;
    logic [LETTER_W-1:0] r_w;
    logic [LETTER_W-1:0] r_wb;
    logic [LETTER_W-1:0] r_s;

    // read data stage
    logic                r_a_vld;
    logic                r_a_last;
    logic                r_a_end;
    logic [LETTER_W-1:0] r_a_shift;

    // product stage
    logic [PROD_W-1:0]   r_prod;
    logic                r_b_vld;
    logic                r_b_last;
    logic                r_b_end;
    logic [LETTER_W-1:0] r_b_shift;

    // accumulate stage
    logic [SCORE_W-1:0]  r_acc;
    logic [SCORE_W-1:0]  r_best;
    logic [LETTER_W-1:0] r_best_shift;
    logic                r_done;

    logic                issue_last;
    logic                issue_end;
    logic [LETTER_W-1:0] n_w;
    logic [LETTER_W-1:0] n_wb;
    logic [SUM_W-1:0]    n_sum;
    logic [SCORE_W-1:0]  n_acc;

    assign issue_last = (r_c == LAST_LETTER);
    assign issue_end  = issue_last && (r_s == LAST_SHIFT);
    assign n_w        = (r_w == LAST_LETTER) ? '0 : r_w + 1'b1;
    assign n_wb       = (r_wb == LAST_LETTER) ? '0 : r_wb + 1'b1;

    assign n_sum = SUM_W'(r_acc) + SUM_W'(r_prod);
    assign n_acc = (|n_sum[SUM_W-1:SCORE_W]) ? SCORE_MAX : n_sum[SCORE_W-1:0];

    assign o_scan.active   = r_run;
    assign o_scan.cnt_addr = r_c;
    assign o_scan.wt_addr  = r_w;
    assign o_done          = r_done;
    assign o_best_shift    = r_best_shift;
    assign o_best_score    = r_best;

    always_ff @(posedge i_clk) begin
        r_a_last  <= issue_last;
        r_a_end   <= issue_end;
        r_a_shift <= r_s;
        r_prod    <= PROD_W'(i_cnt_q) * PROD_W'(i_wt_q);
        r_b_last  <= r_a_last;
        r_b_end   <= r_a_end;
        r_b_shift <= r_a_shift;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run        <= 1'b0;
            r_c          <= '0;
            r_w          <= '0;
            r_wb         <= '0;
            r_s          <= FIRST_SHIFT;
            r_a_vld      <= 1'b0;
            r_b_vld      <= 1'b0;
            r_acc        <= '0;
            r_best       <= '0;
            r_best_shift <= '0;
            r_done       <= 1'b0;
        end else begin
            r_a_vld <= r_run;
            r_b_vld <= r_a_vld;
            r_done  <= 1'b0;
            if (i_start) begin
                r_run        <= 1'b1;
                r_c          <= '0;
                r_w          <= FIRST_SHIFT;
                r_wb         <= FIRST_SHIFT;
                r_s          <= FIRST_SHIFT;
                r_acc        <= '0;
                r_best       <= '0;
                r_best_shift <= '0;
            end else if (r_run) begin
                if (issue_last) begin
                    // advance to the next shift
                    r_c  <= '0;
                    r_s  <= r_s + 1'b1;
                    r_wb <= n_wb;
                    r_w  <= n_wb;
                    if (issue_end) begin
                        r_run <= 1'b0;
                    end
                end else begin
                    r_c <= r_c + 1'b1;
                    r_w <= n_w;
                end
            end
            if (r_b_vld) begin
                if (r_b_last) begin
                    r_acc <= '0;
                    // strict compare keeps the lowest shift on ties
                    if (n_acc > r_best) begin
                        r_best       <= n_acc;
                        r_best_shift <= r_b_shift;
                    end
                    r_done <= r_b_end;
                end else begin
                    r_acc <= n_acc;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_done_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (!r_run && !r_a_vld && !r_b_vld))
        else $error("scan finished with work in flight");
    a_start_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (!r_run && !r_a_vld && !r_b_vld))
        else $error("scan started while busy");
    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_best_shift <= LAST_SHIFT))
        else $error("best shift out of range");
`endif

endmodule

[rtl/caesar_shift_frequency_cracker_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// caesar_shift_frequency_cracker_top
// Cracks a shift cipher by scoring letter counts against reference weights.
// ----------------------------------------------------------------------------
// Input channel (i_valid / o_ready) carries one request: a weight load, a
// ciphertext byte or an evaluate. Loads and bytes are taken one per cycle
// while idle; a byte runs a pipelined read-modify-write on the histogram
// memory, with forwarding when the same letter repeats.
// An evaluate walks 26 shifts times 26 letters through one multiplier, one
// product per cycle, then drains the read, product and accumulate stages;
// o_ready stays low all the while. The result (shift, score) then sits
// in the output register (o_valid / i_ready) and the histogram is cleared.
// If the receiver stalls with an earlier result still waiting, the new result
// is held and o_ready stays low until the output register frees up.
// Reset (synchronous, active low) marks all weights and counts as zero.
// ----------------------------------------------------------------------------
module caesar_shift_frequency_cracker_top import csfc_pkg::*; #(
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
    parameter int WEIGHT_WIDTH = DEF_WEIGHT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [1:0]             i_cmd,
    input  logic [7:0]             i_char_code,
    input  logic [LETTER_W-1:0]    i_letter_index,
    input  logic [WEIGHT_IN_W-1:0] i_weight,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [LETTER_W-1:0]    o_best_shift,
    output logic [SCORE_W-1:0]     o_best_score
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_HOLD = 2'd2;

    logic [1:0]              r_state;
    logic [1:0]              n_state;
    logic                    r_out_vld;
    logic [LETTER_W-1:0]     r_out_shift;
    logic [SCORE_W-1:0]      r_out_score;

    logic                    accept;
    logic                    start;
    logic                    out_free;
    logic                    load_out;
    logic                    score_done;
    logic [LETTER_W-1:0]     best_shift;
    logic [SCORE_W-1:0]      best_score;
    t_scan_rd                scan;
    logic [COUNT_WIDTH-1:0]  cnt_q;
    logic [WEIGHT_WIDTH-1:0] wt_q;

    assign o_ready      = (r_state == S_IDLE);
    assign accept       = i_valid && o_ready;
    assign start        = accept && (i_cmd == CMD_EVAL);
    assign out_free     = !r_out_vld || i_ready;
    assign o_valid      = r_out_vld;
    assign o_best_shift = r_out_shift;
    assign o_best_score = r_out_score;

    csfc_hist #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_byte_vld  (accept && (i_cmd == CMD_BYTE)),
        .i_char_code (i_char_code),
        .i_scan      (scan),
        .i_clear     (score_done),
        .o_cnt_q     (cnt_q)
    );

    csfc_wtab #(
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_wtab (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept && (i_cmd == CMD_LOAD)),
        .i_letter_index (i_letter_index),
        .i_weight       (i_weight),
        .i_scan         (scan),
        .o_wt_q         (wt_q)
    );

    csfc_score #(
        .COUNT_WIDTH  (COUNT_WIDTH),
        .WEIGHT_WIDTH (WEIGHT_WIDTH)
    ) u_score (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_cnt_q      (cnt_q),
        .i_wt_q       (wt_q),
        .o_scan       (scan),
        .o_done       (score_done),
        .o_best_shift (best_shift),
        .o_best_score (best_score)
    );

    always_comb begin
        n_state  = r_state;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (score_done) begin
                    load_out = out_free;
                    n_state  = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                // wait for the receiver to take the earlier result
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_shift <= best_shift;
            r_out_score <= best_score;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    a_hold_means_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_HOLD) |-> r_out_vld)
        else $error("result held while output register is free");
    a_done_only_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        score_done |-> (r_state == S_SCAN))
        else $error("scan result outside of scan");
`endif

endmodule

[tb/sv/csfc_crack_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csfc_crack_checker
// Watches both channels of the shift cracker, predicts every evaluate result
// from its own copy of the weight table and letter histogram, and compares
// each returned (shift, score) pair field by field in order.
// ----------------------------------------------------------------------------
module csfc_crack_checker import csfc_pkg::*; #(
    parameter int COUNT_WIDTH  = DEF_COUNT_WIDTH,
    parameter int WEIGHT_WIDTH = DEF_WEIGHT_WIDTH
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic [1:0]             i_req_cmd,
    input  logic [7:0]             i_req_char,
    input  logic [LETTER_W-1:0]    i_req_letter,
    input  logic [WEIGHT_IN_W-1:0] i_req_weight,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [LETTER_W-1:0]    i_res_shift,
    input  logic [SCORE_W-1:0]     i_res_score,
    output int                     o_fail_count = 0,
    output int                     o_pending = 0
);

    localparam logic [COUNT_WIDTH-1:0]  COUNT_FULL  = '1;
    localparam logic [WEIGHT_WIDTH-1:0] WEIGHT_FULL = '1;
    localparam int                      MAX_REPORTS = 10;

    typedef struct packed {
        logic [LETTER_W-1:0] shift;
        logic [SCORE_W-1:0]  score;
    } t_crack;

    logic [WEIGHT_WIDTH-1:0] ref_freq    [NUM_LETTERS];
    logic [COUNT_WIDTH-1:0]  letter_hist [NUM_LETTERS];
    t_crack                  expected_cracks [$];
    int                      n_fail = 0;

    task automatic note_failure(input string msg);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    // Score every shift against the histogram; the first strictly greater
    // score wins, so an all-zero histogram or table leaves shift 0.
    function automatic t_crack score_best_shift();
        t_crack      best;
        logic [63:0] sum;
        int          s;
        int          c;
        best = '0;
        for (s = FIRST_SHIFT; s <= LAST_SHIFT; s++) begin
            sum = '0;
            for (c = 0; c < NUM_LETTERS; c++)
                sum += 64'(letter_hist[c]) * 64'(ref_freq[(c + s) % NUM_LETTERS]);
            if (sum > 64'(SCORE_MAX))
                sum = 64'(SCORE_MAX);
            if (sum > 64'(best.score)) begin
                best.score = sum[SCORE_W-1:0];
                best.shift = LETTER_W'(s);
            end
        end
        return best;
    endfunction

    always @(posedge i_clk) begin : watch
        t_crack want;
        int     idx;
        int     i;
        if (!i_rst_n) begin
            for (i = 0; i < NUM_LETTERS; i++) begin
                ref_freq[i]    = '0;
                letter_hist[i] = '0;
            end
            expected_cracks.delete();
        end else begin
            // compare first so a result never meets an expectation made this edge
            if (i_res_valid && i_res_ready) begin
                if (expected_cracks.size() == 0) begin
                    note_failure($sformatf("unexpected result: shift %0d score %0d",
                                           i_res_shift, i_res_score));
                end else begin
                    want = expected_cracks.pop_front();
                    if (i_res_shift !== want.shift)
                        note_failure($sformatf("best_shift: expected %0d, got %0d",
                                               want.shift, i_res_shift));
                    if (i_res_score !== want.score)
                        note_failure($sformatf("best_score: expected %0d, got %0d",
                                               want.score, i_res_score));
                end
            end
            if (i_req_valid && i_req_ready) begin
                case (i_req_cmd)
                    CMD_LOAD: begin
                        if (i_req_letter <= LAST_LETTER) begin
                            if (32'(i_req_weight) > 32'(WEIGHT_FULL))
                                ref_freq[i_req_letter] = WEIGHT_FULL;
                            else
                                ref_freq[i_req_letter] = WEIGHT_WIDTH'(i_req_weight);
                        end
                    end
                    CMD_BYTE: begin
                        idx = -1;
                        if (i_req_char >= UPPER_A && i_req_char <= UPPER_Z)
                            idx = int'(i_req_char - UPPER_A);
                        else if (i_req_char >= LOWER_A && i_req_char <= LOWER_Z)
                            idx = int'(i_req_char - LOWER_A);
                        // hold a full count
                        if (idx >= 0 && letter_hist[idx] != COUNT_FULL)
                            letter_hist[idx] = letter_hist[idx] + 1'b1;
                    end
                    CMD_EVAL: begin
                        expected_cracks.push_back(score_best_shift());
                        for (i = 0; i < NUM_LETTERS; i++)
                            letter_hist[i] = '0;
                    end
                    default: ;
                endcase
            end
        end
        o_pending    <= expected_cracks.size();
        o_fail_count <= n_fail;
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives weight loads, ciphertext runs and evaluate requests into the shift
// cracker under random backpressure on both sides; the checker beside the
// block predicts and compares, and this top gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import csfc_pkg::*;

    localparam logic [1:0] CMD_UNUSED     = 2'd3;
    localparam int         ITEM_TARGET    = 1700;
    localparam int         DRAIN_CYCLES   = 720;
    localparam int         WATCHDOG_LIMIT = 4000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_ready;
    logic [1:0]             i_cmd;
    logic [7:0]             i_char_code;
    logic [LETTER_W-1:0]    i_letter_index;
    logic [WEIGHT_IN_W-1:0] i_weight;
    logic                   o_valid;
    logic                   i_ready;
    logic [LETTER_W-1:0]    o_best_shift;
    logic [SCORE_W-1:0]     o_best_score;

    int chk_fail_count;
    int chk_pending;
    int n_effective     = 0;
    int sender_idle_pct = 6;
    int recv_idle_pct   = 53;
    int idle_cycles     = 0;

    caesar_shift_frequency_cracker_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_char_code    (i_char_code),
        .i_letter_index (i_letter_index),
        .i_weight       (i_weight),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_best_shift   (o_best_shift),
        .o_best_score   (o_best_score)
    );

    csfc_crack_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_req_cmd    (i_cmd),
        .i_req_char   (i_char_code),
        .i_req_letter (i_letter_index),
        .i_req_weight (i_weight),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_res_shift  (o_best_shift),
        .i_res_score  (o_best_score),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // End the run when neither channel moves for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("caesar_shift_frequency_cracker_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_request(input logic [1:0]             cmd,
                                input logic [7:0]             ch,
                                input logic [LETTER_W-1:0]    idx,
                                input logic [WEIGHT_IN_W-1:0] w);
        logic counted;
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_cmd          <= cmd;
        i_char_code    <= ch;
        i_letter_index <= idx;
        i_weight       <= w;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        case (cmd)
            CMD_LOAD: counted = (idx <= LAST_LETTER);
            CMD_BYTE: counted = (ch >= UPPER_A && ch <= UPPER_Z) ||
                                (ch >= LOWER_A && ch <= LOWER_Z);
            CMD_EVAL: counted = 1'b1;
            default:  counted = 1'b0;
        endcase
        if (counted)
            n_effective++;
        // advance the backpressure phase
        if (n_effective >= 2 * ITEM_TARGET / 3) begin
            sender_idle_pct = 0;
            recv_idle_pct   = 0;
        end else if (n_effective >= ITEM_TARGET / 3) begin
            sender_idle_pct = 53;
            recv_idle_pct   = 6;
        end
    endtask

    initial begin : stimulus
        int                     pick;
        int                     shape;
        int                     shift_key;
        int                     n;
        logic [WEIGHT_IN_W-1:0] flat_weight;
        logic [7:0]             ch;

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_cmd          = CMD_LOAD;
        i_char_code    = '0;
        i_letter_index = '0;
        i_weight       = '0;
        i_ready        = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty histogram, then letters against an all-zero table
        send_request(CMD_EVAL, 8'h00, '0, '0);
        send_request(CMD_BYTE, UPPER_A, '1, '1);
        send_request(CMD_BYTE, LOWER_Z, '0, '0);
        send_request(CMD_EVAL, 8'hFF, '1, '1);
        // weight extremes, out-of-range letters, unused command
        send_request(CMD_LOAD, 8'h00, '0, '1);
        send_request(CMD_LOAD, 8'hFF, LAST_LETTER, '0);
        send_request(CMD_LOAD, 8'h00, LAST_LETTER + 1'b1, 16'h1234);
        send_request(CMD_LOAD, 8'h00, '1, '1);
        send_request(CMD_UNUSED, LOWER_A, '0, '1);
        // letter boundaries and bytes that must be ignored
        send_request(CMD_BYTE, UPPER_Z, '0, '0);
        send_request(CMD_BYTE, LOWER_A, '0, '0);
        send_request(CMD_BYTE, UPPER_A - 1'b1, '0, '0);
        send_request(CMD_BYTE, UPPER_Z + 1'b1, '0, '0);
        send_request(CMD_BYTE, LOWER_A - 1'b1, '0, '0);
        send_request(CMD_BYTE, LOWER_Z + 1'b1, '0, '0);
        send_request(CMD_BYTE, 8'h00, '0, '0);
        send_request(CMD_BYTE, 8'hFF, '0, '0);
        send_request(CMD_BYTE, 8'h80, '0, '0);
        send_request(CMD_EVAL, 8'h00, '0, '0);
        // shifts 13 and 26 tie on a single 'a'; the lower one must win
        send_request(CMD_LOAD, 8'h00, LETTER_W'(13), '1);
        send_request(CMD_BYTE, LOWER_A, '0, '0);
        send_request(CMD_EVAL, 8'h00, '0, '0);

        while (n_effective < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                // noise: any code, any field value
                repeat ($urandom_range(1, 6))
                    send_request(2'($urandom_range(0, 3)), 8'($urandom),
                                 LETTER_W'($urandom), WEIGHT_IN_W'($urandom));
            end else begin
                if (pick < 20) begin
                    // fresh table: random, flat (every shift ties) or sparse
                    shape       = $urandom_range(0, 2);
                    flat_weight = WEIGHT_IN_W'($urandom);
                    for (n = 0; n < NUM_LETTERS; n++)
                        send_request(CMD_LOAD, 8'($urandom), LETTER_W'(n),
                                     (shape == 0) ? WEIGHT_IN_W'($urandom) :
                                     (shape == 1) ? flat_weight :
                                     ($urandom_range(0, 3) == 0) ? WEIGHT_IN_W'($urandom) :
                                                                   '0);
                end else begin
                    repeat ($urandom_range(0, 3))
                        send_request(CMD_LOAD, 8'($urandom),
                                     LETTER_W'($urandom_range(0, NUM_LETTERS - 1)),
                                     WEIGHT_IN_W'($urandom));
                end
                // ciphertext skewed around a key so the winner moves around
                shift_key = $urandom_range(0, NUM_LETTERS - 1);
                repeat ($urandom_range(0, 40)) begin
                    if ($urandom_range(0, 99) < 15) begin
                        ch = 8'($urandom);
                    end else begin
                        n  = $urandom_range(0, 1) ? (shift_key + $urandom_range(0, 4))
                                                  : $urandom_range(0, NUM_LETTERS - 1);
                        ch = ($urandom_range(0, 1) ? UPPER_A : LOWER_A)
                             + 8'(n % NUM_LETTERS);
                    end
                    send_request(CMD_BYTE, ch, LETTER_W'($urandom), WEIGHT_IN_W'($urandom));
                end
                // now and then skip the evaluate so counts run on
                if ($urandom_range(0, 9) != 0)
                    send_request(CMD_EVAL, 8'($urandom), LETTER_W'($urandom),
                                 WEIGHT_IN_W'($urandom));
            end
        end

        i_valid <= 1'b0;
        @(posedge i_clk);
        while (chk_pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk_fail_count == 0 && chk_pending == 0)
            $display("caesar_shift_frequency_cracker_top verification clean");
        else
            $display("caesar_shift_frequency_cracker_top verification failed");
        $finish;
    end

endmodule
